>>> rtl/lpr_pkg.sv
// lpr_pkg: sizes, frame table row layout and lookup status for the LRU page
// replacement block. No dependencies; used by lpr_lookup and lru_page_replacement.
package lpr_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int PAGE_BITS  = 16;

  localparam int PORT_PAGE_W = 16;
  localparam int PORT_FRAME_W = 4;
  localparam int CNT_W      = 16;
  localparam int CFG_W      = 5;
  localparam int CFG_RESET  = 16;

  localparam int FIDX_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int RANK_W  = FIDX_W;
  localparam int COUNT_W = $clog2(NUM_FRAMES + 1);

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [FIDX_W-1:0]    fidx_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [NUM_FRAMES-1:0] fvec_t;

  typedef struct packed {
    page_t             page;
    logic [RANK_W-1:0] rank;
  } frame_t;

  typedef frame_t [NUM_FRAMES-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic  hit;
    logic  fill;
    logic  evict;
    fidx_t frame;
  } lookup_t;

endpackage

>>> rtl/lpr_ram.sv
// lpr_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lpr_lookup.sv
// lpr_lookup: parallel page match, empty-frame and victim search, and the
// recency rank update of one frame table row. Depends on lpr_pkg.
module lpr_lookup (
  input  lpr_pkg::row_t    row,
  input  lpr_pkg::fvec_t   valid,
  input  lpr_pkg::page_t   page,
  input  lpr_pkg::count_t  active_n,
  output lpr_pkg::lookup_t res,
  output lpr_pkg::row_t    row_next,
  output lpr_pkg::fvec_t   valid_next,
  output lpr_pkg::page_t   ev_page
);

  lpr_pkg::fvec_t  active;
  lpr_pkg::fvec_t  match;
  lpr_pkg::fvec_t  empty;
  lpr_pkg::fvec_t  is_max;
  logic            hit_found;
  logic            empty_found;
  lpr_pkg::fidx_t  hit_f;
  lpr_pkg::fidx_t  empty_f;
  lpr_pkg::fidx_t  victim_f;
  lpr_pkg::fidx_t  f;
  logic [lpr_pkg::RANK_W-1:0] f_rank;

  always_comb begin
    for (int j = 0; j < lpr_pkg::NUM_FRAMES; j++) begin
      active[j] = (lpr_pkg::COUNT_W'(j) < active_n);
      match[j]  = active[j] && valid[j] && (row[j].page == page);
      empty[j]  = active[j] && !valid[j];
    end
    for (int j = 0; j < lpr_pkg::NUM_FRAMES; j++) begin
      is_max[j] = active[j];
      for (int k = 0; k < lpr_pkg::NUM_FRAMES; k++) begin
        if (active[k] && (row[k].rank > row[j].rank)) begin
          is_max[j] = 1'b0;
        end
      end
    end
    hit_found   = 1'b0;
    empty_found = 1'b0;
    hit_f       = '0;
    empty_f     = '0;
    victim_f    = '0;
    for (int j = lpr_pkg::NUM_FRAMES - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_found = 1'b1;
        hit_f     = lpr_pkg::FIDX_W'(j);
      end
      if (empty[j]) begin
        empty_found = 1'b1;
        empty_f     = lpr_pkg::FIDX_W'(j);
      end
      if (is_max[j]) begin
        victim_f = lpr_pkg::FIDX_W'(j);
      end
    end
  end

  always_comb begin
    res.hit   = hit_found;
    res.fill  = !hit_found && empty_found;
    res.evict = !hit_found && !empty_found;
    if (hit_found) begin
      f = hit_f;
    end else if (empty_found) begin
      f = empty_f;
    end else begin
      f = victim_f;
    end
    res.frame = f;
    f_rank    = row[f].rank;
  end

  always_comb begin
    for (int j = 0; j < lpr_pkg::NUM_FRAMES; j++) begin
      row_next[j] = row[j];
      if (lpr_pkg::FIDX_W'(j) == f) begin
        row_next[j].rank = '0;
        if (!res.hit) begin
          row_next[j].page = page;
        end
      end else if (valid[j] && (res.fill || (row[j].rank < f_rank))) begin
        row_next[j].rank = row[j].rank + 1'b1;
      end
      valid_next[j] = valid[j] || (res.fill && (lpr_pkg::FIDX_W'(j) == f));
    end
    ev_page = res.evict ? row[f].page : '0;
  end

endmodule

>>> rtl/lru_page_replacement.sv
// lru_page_replacement: top level; frame table RAM, valid bits, counters,
// request control. Depends on lpr_pkg, lpr_ram, lpr_lookup.
//
//   channel   ports                                         handshake
//   request   page_number                                   start, busy
//   result    page_hit frame_touched evicted_valid          done (one cycle)
//             evicted_page total_hits total_faults
//   config    frames_in_use                                 frames_in_use_we
//
// For each request, the frame table row is read from the RAM at
// accept, then compared, updated and written back in the following cycle,
// while busy is high. done pulses in the cycle after that.
// Frame valid bits are flops, so reset needs no clearing pass.
// The result side cannot stall.
module lru_page_replacement (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [lpr_pkg::PORT_PAGE_W-1:0]    page_number,
  input  logic                               frames_in_use_we,
  input  logic [lpr_pkg::CFG_W-1:0]          frames_in_use,
  output logic                               done,
  output logic                               page_hit,
  output logic [lpr_pkg::PORT_FRAME_W-1:0]   frame_touched,
  output logic                               evicted_valid,
  output logic [lpr_pkg::PORT_PAGE_W-1:0]    evicted_page,
  output logic [lpr_pkg::CNT_W-1:0]          total_hits,
  output logic [lpr_pkg::CNT_W-1:0]          total_faults
);

  logic                      accept;
  logic [lpr_pkg::CFG_W-1:0] cfg_frames;
  lpr_pkg::count_t           active_n;
  lpr_pkg::page_t            page;
  lpr_pkg::fvec_t            frame_valid;
  lpr_pkg::fvec_t            valid_next;
  lpr_pkg::row_t             row;
  lpr_pkg::row_t             row_next;
  lpr_pkg::lookup_t          res;
  lpr_pkg::page_t            ev_page;
  logic [lpr_pkg::CNT_W-1:0] hit_total;
  logic [lpr_pkg::CNT_W-1:0] fault_total;
  logic [lpr_pkg::CNT_W-1:0] hit_total_next;
  logic [lpr_pkg::CNT_W-1:0] fault_total_next;
  logic [lpr_pkg::ROW_W-1:0] rdata;

  assign accept = start && !busy;
  assign row    = lpr_pkg::row_t'(rdata);

  always_comb begin
    if (cfg_frames == '0) begin
      active_n = lpr_pkg::COUNT_W'(1);
    end else if (32'(cfg_frames) > 32'(lpr_pkg::NUM_FRAMES)) begin
      active_n = lpr_pkg::COUNT_W'(lpr_pkg::NUM_FRAMES);
    end else begin
      active_n = lpr_pkg::COUNT_W'(cfg_frames);
    end
  end

  lpr_ram #(
    .WIDTH (lpr_pkg::ROW_W),
    .DEPTH (1)
  ) u_table (
    .clk   (clk),
    .we    (busy),
    .waddr (1'b0),
    .wdata (lpr_pkg::ROW_W'(row_next)),
    .re    (accept),
    .raddr (1'b0),
    .rdata (rdata)
  );

  lpr_lookup u_lookup (
    .row        (row),
    .valid      (frame_valid),
    .page       (page),
    .active_n   (active_n),
    .res        (res),
    .row_next   (row_next),
    .valid_next (valid_next),
    .ev_page    (ev_page)
  );

  always_comb begin
    hit_total_next   = hit_total;
    fault_total_next = fault_total;
    if (res.hit) begin
      if (hit_total != '1) begin
        hit_total_next = hit_total + 1'b1;
      end
    end else if (fault_total != '1) begin
      fault_total_next = fault_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      done        <= 1'b0;
      frame_valid <= '0;
      hit_total   <= '0;
      fault_total <= '0;
      cfg_frames  <= lpr_pkg::CFG_W'(lpr_pkg::CFG_RESET);
    end else begin
      done <= busy;
      if (frames_in_use_we) begin
        cfg_frames <= frames_in_use;
      end
      if (accept) begin
        busy <= 1'b1;
      end
      if (busy) begin
        busy        <= 1'b0;
        frame_valid <= valid_next;
        hit_total   <= hit_total_next;
        fault_total <= fault_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page <= lpr_pkg::PAGE_BITS'(page_number);
    end
    if (busy) begin
      page_hit      <= res.hit;
      frame_touched <= lpr_pkg::PORT_FRAME_W'(res.frame);
      evicted_valid <= res.evict;
      evicted_page  <= lpr_pkg::PORT_PAGE_W'(ev_page);
    end
  end

  assign total_hits   = hit_total;
  assign total_faults = fault_total;

`ifndef SYNTHESIS
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && done))
    else $error("request held busy for more than one cycle");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && page_hit) |-> (!evicted_valid && (evicted_page == '0)))
    else $error("hit reported an eviction");

  a_valid_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((frame_valid & $past(frame_valid)) == $past(frame_valid)))
    else $error("frame valid bit cleared");

  a_counters_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |=> ($stable(hit_total) && $stable(fault_total)))
    else $error("counter changed without a request");
`endif

endmodule

>>> tb/lru_page_replacement_tb.sv
// lru_page_replacement_tb: self-checking testbench for the LRU page replacement block.
// Tracks frames, recency ranks and totals in a scoreboard class and checks every done.
// Depends on lpr_pkg and lru_page_replacement.
module lru_page_replacement_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_SHOWN = 10;

  typedef logic [lpr_pkg::PORT_PAGE_W-1:0] port_page_t;

  typedef struct {
    logic                             hit;
    logic [lpr_pkg::PORT_FRAME_W-1:0] frame;
    logic                             ev_valid;
    logic [lpr_pkg::PORT_PAGE_W-1:0]  ev_page;
    logic [lpr_pkg::CNT_W-1:0]        hits;
    logic [lpr_pkg::CNT_W-1:0]        faults;
  } lru_outcome_t;

  class lru_outcome_board;
    lpr_pkg::page_t            frame_pg[lpr_pkg::NUM_FRAMES];
    bit                        frame_used[lpr_pkg::NUM_FRAMES];
    int                        frame_age[lpr_pkg::NUM_FRAMES];
    int                        hit_cnt;
    int                        fault_cnt;
    logic [lpr_pkg::CFG_W-1:0] frames_cfg;
    lru_outcome_t              outcomes_due[$];
    int                        mismatches;

    function new();
      for (int j = 0; j < lpr_pkg::NUM_FRAMES; j++) begin
        frame_pg[j] = '0;
        frame_used[j] = 1'b0;
        frame_age[j] = 0;
      end
      hit_cnt = 0;
      fault_cnt = 0;
      frames_cfg = lpr_pkg::CFG_W'(lpr_pkg::CFG_RESET);
      mismatches = 0;
    endfunction

    function void set_frames(logic [lpr_pkg::CFG_W-1:0] v);
      frames_cfg = v;
    endfunction

    function void make_newest(int f, int limit);
      for (int j = 0; j < lpr_pkg::NUM_FRAMES; j++)
        if (j != f && frame_used[j] && frame_age[j] < limit) frame_age[j]++;
      frame_age[f] = 0;
    endfunction

    function void take_request(port_page_t pg_in);
      lpr_pkg::page_t pg;
      int             n;
      int             f;
      int             best;
      bit             found;
      lru_outcome_t   o;
      pg = lpr_pkg::page_t'(pg_in);
      n = (frames_cfg == 0) ? 1 :
          (frames_cfg > lpr_pkg::NUM_FRAMES) ? lpr_pkg::NUM_FRAMES : int'(frames_cfg);
      f = 0;
      found = 1'b0;
      o.ev_valid = 1'b0;
      o.ev_page = '0;
      for (int j = 0; j < n && !found; j++)
        if (frame_used[j] && frame_pg[j] == pg) begin
          found = 1'b1;
          f = j;
        end
      o.hit = found;
      if (found) begin
        make_newest(f, frame_age[f]);
        if (hit_cnt < 65535) hit_cnt++;
      end else begin
        for (int j = 0; j < n && !found; j++)
          if (!frame_used[j]) begin
            found = 1'b1;
            f = j;
          end
        if (found) begin
          frame_used[f] = 1'b1;
          frame_pg[f] = pg;
          make_newest(f, lpr_pkg::NUM_FRAMES + 1);
        end else begin
          best = 0;
          f = 0;
          for (int j = 0; j < n; j++)
            if (frame_age[j] > best) begin
              best = frame_age[j];
              f = j;
            end
          o.ev_valid = 1'b1;
          o.ev_page = lpr_pkg::PORT_PAGE_W'(frame_pg[f]);
          frame_pg[f] = pg;
          make_newest(f, frame_age[f]);
        end
        if (fault_cnt < 65535) fault_cnt++;
      end
      o.frame = lpr_pkg::PORT_FRAME_W'(f);
      o.hits = lpr_pkg::CNT_W'(hit_cnt);
      o.faults = lpr_pkg::CNT_W'(fault_cnt);
      outcomes_due.push_back(o);
    endfunction

    function void compare_outcome(lru_outcome_t got);
      lru_outcome_t want;
      if (outcomes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: unexpected result hit=%0b frame=%0d", $realtime, got.hit, got.frame);
        return;
      end
      want = outcomes_due.pop_front();
      if (got.hit !== want.hit || got.frame !== want.frame ||
          got.ev_valid !== want.ev_valid || got.ev_page !== want.ev_page ||
          got.hits !== want.hits || got.faults !== want.faults) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("%0t: mismatch expected hit=%0b frame=%0d ev=%0b/%h hits=%0d faults=%0d",
                   $realtime, want.hit, want.frame, want.ev_valid, want.ev_page,
                   want.hits, want.faults);
          $display("%0t:          actual hit=%0b frame=%0d ev=%0b/%h hits=%0d faults=%0d",
                   $realtime, got.hit, got.frame, got.ev_valid, got.ev_page,
                   got.hits, got.faults);
        end
      end
    endfunction

    function void close_out();
      mismatches += outcomes_due.size();
      if (outcomes_due.size() != 0)
        $display("%0t: %0d results never arrived", $realtime, outcomes_due.size());
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             start;
  logic                             busy;
  logic [lpr_pkg::PORT_PAGE_W-1:0]  page_number;
  logic                             frames_in_use_we;
  logic [lpr_pkg::CFG_W-1:0]        frames_in_use;
  logic                             done;
  logic                             page_hit;
  logic [lpr_pkg::PORT_FRAME_W-1:0] frame_touched;
  logic                             evicted_valid;
  logic [lpr_pkg::PORT_PAGE_W-1:0]  evicted_page;
  logic [lpr_pkg::CNT_W-1:0]        total_hits;
  logic [lpr_pkg::CNT_W-1:0]        total_faults;

  lru_outcome_board frame_board = new();
  int               cycle_count = 0;
  port_page_t       page_pool[$];

  lru_page_replacement u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .page_number      (page_number),
    .frames_in_use_we (frames_in_use_we),
    .frames_in_use    (frames_in_use),
    .done             (done),
    .page_hit         (page_hit),
    .frame_touched    (frame_touched),
    .evicted_valid    (evicted_valid),
    .evicted_page     (evicted_page),
    .total_hits       (total_hits),
    .total_faults     (total_faults)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lru_page_replacement_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    lru_outcome_t got;
    if (!rst && done) begin
      got.hit = page_hit;
      got.frame = frame_touched;
      got.ev_valid = evicted_valid;
      got.ev_page = evicted_page;
      got.hits = total_hits;
      got.faults = total_faults;
      frame_board.compare_outcome(got);
    end
  end

  task automatic send_request(port_page_t pg, int gap);
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    page_number <= pg;
    do @(posedge clk); while (busy);
    frame_board.take_request(pg);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (frame_board.outcomes_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_frames(logic [lpr_pkg::CFG_W-1:0] v);
    drain_results();
    frames_in_use_we <= 1'b1;
    frames_in_use <= v;
    frame_board.set_frames(v);
    @(negedge clk);
    frames_in_use_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int pick_gap(int idle_pct);
    if ($urandom_range(99) < idle_pct) return $urandom_range(1, 6);
    return 0;
  endfunction

  initial begin
    logic [lpr_pkg::CFG_W-1:0] phase_frames[8];
    int                        idle_pct[4];
    port_page_t                pg;
    phase_frames = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd9, 5'd17, 5'd16};
    idle_pct = '{0, 74, 0, 24};
    rst = 1'b1;
    start = 1'b0;
    page_number = '0;
    frames_in_use_we = 1'b0;
    frames_in_use = lpr_pkg::CFG_W'(lpr_pkg::CFG_RESET);
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill from empty, hit, then shrink / zero / oversize the frame set
    send_request(16'h0000, 0);
    send_request(16'hFFFF, 0);
    send_request(16'h0000, 0);
    send_request(16'h5555, 1);
    send_request(16'hAAAA, 0);
    write_frames(5'd2);
    send_request(16'h1234, 0);
    send_request(16'h5555, 0);
    send_request(16'hFFFF, 2);
    write_frames(5'd0);
    send_request(16'h5555, 0);
    send_request(16'h0F0F, 0);
    write_frames(5'd31);
    send_request(16'h5555, 0);
    send_request(16'h8001, 0);
    send_request(16'h1234, 0);
    send_request(16'hAAAA, 0);
    write_frames(5'd17);
    send_request(16'h7FFE, 0);
    send_request(16'h0F0F, 0);

    for (int k = 0; k < 8; k++) begin
      write_frames(phase_frames[k]);
      page_pool.delete();
      repeat ($urandom_range(3, 24)) page_pool.push_back(port_page_t'($urandom));
      for (int i = 0; i < 90; i++) begin
        if (k == 1 && i == 45) drain_results();
        if ($urandom_range(99) < 80) pg = page_pool[$urandom_range(page_pool.size() - 1)];
        else pg = port_page_t'($urandom);
        send_request(pg, pick_gap(idle_pct[k % 4]));
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    frame_board.close_out();
    if (frame_board.mismatches == 0)
      $display("lru_page_replacement_tb: done, clean");
    else
      $display("lru_page_replacement_tb: done, errors");
    $finish;
  end

endmodule
